@@ hw/rtl/cls_pkg.sv @@
// Shared constants, command codes and control/status structs for the cursor list store.
package cls_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int LEN_W    = 5;
  localparam int SEL_W    = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TO_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TO_END   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PREV     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd7;

  // Read address select.
  localparam logic [SEL_W-1:0] RD_IDX_M1  = 2'd0;
  localparam logic [SEL_W-1:0] RD_IDX_P1  = 2'd1;
  localparam logic [SEL_W-1:0] RD_CURSOR  = 2'd2;

  // Write address and data select.
  localparam logic [SEL_W-1:0] WR_SHIFT     = 2'd0;
  localparam logic [SEL_W-1:0] WR_AT_CURSOR = 2'd1;
  localparam logic [SEL_W-1:0] WR_AT_END    = 2'd2;

  typedef struct packed {
    logic             latch_in;
    logic             set_rej;
    logic             cur_zero;
    logic             cur_end;
    logic             cur_dec;
    logic             cur_inc;
    logic             clear;
    logic             idx_from_count;
    logic             idx_from_cursor;
    logic             idx_dec;
    logic             idx_inc;
    logic             rd_en;
    logic [SEL_W-1:0] rd_sel;
    logic             wr_en;
    logic [SEL_W-1:0] wr_sel;
    logic             count_inc;
    logic             count_dec;
    logic             take_rem;
    logic             load_out;
  } cls_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             at_end;
    logic             at_start;
    logic             ins_more;
    logic             rem_first;
    logic             rem_more;
    logic             out_busy;
  } cls_stat_t;

endpackage

@@ hw/rtl/cls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/cls_datapath.sv @@
// Datapath of the cursor list store: element memory, count, cursor, index and result registers.
module cls_datapath #(
  parameter int CAPACITY = cls_pkg::CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cls_pkg::cls_ctrl_t                ctrl,
  output cls_pkg::cls_stat_t                stat,
  input  logic [cls_pkg::CMD_W-1:0]         command,
  input  logic signed [cls_pkg::DATA_W-1:0] element_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cls_pkg::DATA_W-1:0] removed_value,
  output logic                              removed_valid,
  output logic signed [cls_pkg::DATA_W-1:0] current_value,
  output logic                              current_valid,
  output logic [cls_pkg::LEN_W-1:0]         length_now,
  output logic [cls_pkg::LEN_W-1:0]         position_now,
  output logic                              rejected
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [cls_pkg::CMD_W-1:0]  cmd_q;
  logic [cls_pkg::DATA_W-1:0] val_q;
  logic [CW-1:0]              count;
  logic [CW-1:0]              cursor;
  logic [CW-1:0]              idx;
  logic [cls_pkg::DATA_W-1:0] rem_value_w;
  logic                       rem_valid_w;
  logic                       rej_w;

  logic [CW-1:0]              rd_pos;
  logic [CW-1:0]              wr_pos;
  logic [cls_pkg::DATA_W-1:0] wr_data;
  logic [cls_pkg::DATA_W-1:0] rdata;
  logic                       cur_on_elem;

  always_comb begin
    case (ctrl.rd_sel)
      cls_pkg::RD_IDX_M1: rd_pos = idx - CW'(1);
      cls_pkg::RD_IDX_P1: rd_pos = idx + CW'(1);
      default:            rd_pos = cursor;
    endcase
    case (ctrl.wr_sel)
      cls_pkg::WR_SHIFT: begin
        wr_pos  = idx;
        wr_data = rdata;
      end
      cls_pkg::WR_AT_CURSOR: begin
        wr_pos  = cursor;
        wr_data = val_q;
      end
      default: begin
        wr_pos  = count;
        wr_data = val_q;
      end
    endcase
  end

  cls_ram #(
    .WIDTH(cls_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.wr_en),
    .waddr(wr_pos[AW-1:0]),
    .wdata(wr_data),
    .re   (ctrl.rd_en),
    .raddr(rd_pos[AW-1:0]),
    .rdata(rdata)
  );

  assign cur_on_elem = (cursor < count);

  always_comb begin
    stat.cmd       = cmd_q;
    stat.full      = (count == CW'(CAPACITY));
    stat.at_end    = !cur_on_elem;
    stat.at_start  = (cursor == '0);
    stat.ins_more  = ({1'b0, idx} > ({1'b0, cursor} + (CW+1)'(1)));
    stat.rem_first = (({1'b0, cursor} + (CW+1)'(1)) < {1'b0, count});
    stat.rem_more  = (({1'b0, idx} + (CW+1)'(2)) < {1'b0, count});
    stat.out_busy  = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
    end else begin
      if (ctrl.clear) begin
        count  <= '0;
        cursor <= '0;
      end else begin
        if (ctrl.count_inc) begin
          count <= count + CW'(1);
        end else if (ctrl.count_dec) begin
          count <= count - CW'(1);
        end
        if (ctrl.cur_zero) begin
          cursor <= '0;
        end else if (ctrl.cur_end) begin
          cursor <= count;
        end else if (ctrl.cur_dec) begin
          cursor <= cursor - CW'(1);
        end else if (ctrl.cur_inc) begin
          cursor <= cursor + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      cmd_q       <= command;
      val_q       <= element_in;
      rem_value_w <= '1;
      rem_valid_w <= 1'b0;
      rej_w       <= 1'b0;
    end else begin
      if (ctrl.set_rej) begin
        rej_w <= 1'b1;
      end
      if (ctrl.take_rem) begin
        rem_value_w <= rdata;
        rem_valid_w <= 1'b1;
      end
    end
    if (ctrl.idx_from_count) begin
      idx <= count;
    end else if (ctrl.idx_from_cursor) begin
      idx <= cursor;
    end else if (ctrl.idx_dec) begin
      idx <= idx - CW'(1);
    end else if (ctrl.idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  // Result register; the controller loads it only once the previous item has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      removed_value <= rem_value_w;
      removed_valid <= rem_valid_w;
      current_value <= cur_on_elem ? rdata : '0;
      current_valid <= cur_on_elem;
      length_now    <= cls_pkg::LEN_W'({{cls_pkg::LEN_W{1'b0}}, count});
      position_now  <= cls_pkg::LEN_W'({{cls_pkg::LEN_W{1'b0}}, cursor});
      rejected      <= rej_w;
    end
  end

endmodule

@@ hw/rtl/cls_controller.sv @@
// Controller state machine that sequences each command of the cursor list store.
module cls_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cls_pkg::cls_stat_t stat,
  output cls_pkg::cls_ctrl_t ctrl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_UP_RD    = 4'd2;
  localparam logic [3:0] S_UP_WR    = 4'd3;
  localparam logic [3:0] S_PUT      = 4'd4;
  localparam logic [3:0] S_REM_WAIT = 4'd5;
  localparam logic [3:0] S_DN_RD    = 4'd6;
  localparam logic [3:0] S_DN_WR    = 4'd7;
  localparam logic [3:0] S_DEC      = 4'd8;
  localparam logic [3:0] S_CUR_RD   = 4'd9;
  localparam logic [3:0] S_CUR_WAIT = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    ctrl        = '0;
    ctrl.rd_sel = cls_pkg::RD_CURSOR;
    ctrl.wr_sel = cls_pkg::WR_SHIFT;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.latch_in = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_CUR_RD;
        case (stat.cmd)
          cls_pkg::CMD_INSERT: begin
            if (stat.full) begin
              ctrl.set_rej = 1'b1;
            end else begin
              ctrl.idx_from_count = 1'b1;
              state_next = stat.at_end ? S_PUT : S_UP_RD;
            end
          end
          cls_pkg::CMD_APPEND: begin
            if (stat.full) begin
              ctrl.set_rej = 1'b1;
            end else begin
              ctrl.wr_en     = 1'b1;
              ctrl.wr_sel    = cls_pkg::WR_AT_END;
              ctrl.count_inc = 1'b1;
            end
          end
          cls_pkg::CMD_REMOVE: begin
            if (!stat.at_end) begin
              ctrl.rd_en           = 1'b1;
              ctrl.rd_sel          = cls_pkg::RD_CURSOR;
              ctrl.idx_from_cursor = 1'b1;
              state_next           = S_REM_WAIT;
            end
          end
          cls_pkg::CMD_TO_START: ctrl.cur_zero = 1'b1;
          cls_pkg::CMD_TO_END:   ctrl.cur_end  = 1'b1;
          cls_pkg::CMD_PREV:     ctrl.cur_dec  = !stat.at_start;
          cls_pkg::CMD_NEXT:     ctrl.cur_inc  = !stat.at_end;
          default:               ctrl.clear    = 1'b1;
        endcase
      end
      // Insert: move elements up one place, from the end down to the cursor.
      S_UP_RD: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = cls_pkg::RD_IDX_M1;
        state_next  = S_UP_WR;
      end
      S_UP_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_sel  = cls_pkg::WR_SHIFT;
        ctrl.idx_dec = 1'b1;
        state_next   = stat.ins_more ? S_UP_RD : S_PUT;
      end
      S_PUT: begin
        ctrl.wr_en     = 1'b1;
        ctrl.wr_sel    = cls_pkg::WR_AT_CURSOR;
        ctrl.count_inc = 1'b1;
        state_next     = S_CUR_RD;
      end
      // Remove: keep the element, then move later elements down one place.
      S_REM_WAIT: begin
        ctrl.take_rem = 1'b1;
        state_next    = stat.rem_first ? S_DN_RD : S_DEC;
      end
      S_DN_RD: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = cls_pkg::RD_IDX_P1;
        state_next  = S_DN_WR;
      end
      S_DN_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_sel  = cls_pkg::WR_SHIFT;
        ctrl.idx_inc = 1'b1;
        state_next   = stat.rem_more ? S_DN_RD : S_DEC;
      end
      S_DEC: begin
        ctrl.count_dec = 1'b1;
        state_next     = S_CUR_RD;
      end
      S_CUR_RD: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = cls_pkg::RD_CURSOR;
        state_next  = S_CUR_WAIT;
      end
      S_CUR_WAIT: begin
        if (!stat.out_busy) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/cursor_list_store.sv @@
// Top level of the cursor list store: controller and datapath.
// Each item passes the decide state, a read at the cursor and the wait for the result register.
// Cursor moves, clear, append, a refused insert or append and a remove at the end add nothing;
// insert adds the moves and a put, a remove that deletes adds a keep, the moves and a decrement
// (each move is a read, then a write). A new item is taken only once the last result is loaded,
// so the next item is taken while a result waits. Reset clears the length, the cursor, the
// controller and the result valid; elements are not cleared and unwritten ones reach no result.
module cursor_list_store #(
  parameter int CAPACITY = cls_pkg::CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cls_pkg::CMD_W-1:0]         command,
  input  logic signed [cls_pkg::DATA_W-1:0] element_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cls_pkg::DATA_W-1:0] removed_value,
  output logic                              removed_valid,
  output logic signed [cls_pkg::DATA_W-1:0] current_value,
  output logic                              current_valid,
  output logic [cls_pkg::LEN_W-1:0]         length_now,
  output logic [cls_pkg::LEN_W-1:0]         position_now,
  output logic                              rejected
);

  cls_pkg::cls_ctrl_t ctrl;
  cls_pkg::cls_stat_t stat;

  cls_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  cls_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .element_in   (element_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .removed_value(removed_value),
    .removed_valid(removed_valid),
    .current_value(current_value),
    .current_valid(current_valid),
    .length_now   (length_now),
    .position_now (position_now),
    .rejected     (rejected)
  );

endmodule

@@ tb/tb_cursor_list_store.sv @@
// Testbench for the cursor list store: directed and random commands, checked against a predictor.
`timescale 1ns / 1ps

module tb_cursor_list_store;
  import cls_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] val;
  } list_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic                     removed_valid;
    logic signed [DATA_W-1:0] current_value;
    logic                     current_valid;
    logic [LEN_W-1:0]         length_now;
    logic [LEN_W-1:0]         position_now;
    logic                     rejected;
  } list_view_t;

  localparam logic signed [DATA_W-1:0] NOTHING_REMOVED = -1;
  localparam logic signed [DATA_W-1:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         command = CMD_CLEAR;
  logic signed [DATA_W-1:0] element_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] removed_value;
  logic                     removed_valid;
  logic signed [DATA_W-1:0] current_value;
  logic                     current_valid;
  logic [LEN_W-1:0]         length_now;
  logic [LEN_W-1:0]         position_now;
  logic                     rejected;

  cursor_list_store i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .element_in    (element_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .removed_value (removed_value),
    .removed_valid (removed_valid),
    .current_value (current_value),
    .current_valid (current_valid),
    .length_now    (length_now),
    .position_now  (position_now),
    .rejected      (rejected)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the list held by the predictor.
  logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
  int unsigned              shadow_len = 0;
  int unsigned              shadow_cur = 0;

  list_cmd_t  cmd_q[$];
  list_view_t view_q[$];

  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_removed = 0;
  int unsigned n_rejected = 0;
  int unsigned n_err = 0;

  function automatic list_view_t list_apply(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
    list_view_t v;
    v = '0;
    v.removed_value = NOTHING_REMOVED;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          v.rejected = 1'b1;
        end else begin
          for (int i = shadow_len; i > shadow_cur; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[shadow_cur] = val;
          shadow_len++;
        end
      end
      CMD_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          v.rejected = 1'b1;
        end else begin
          shadow_cells[shadow_len] = val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_cur < shadow_len) begin
          v.removed_value = shadow_cells[shadow_cur];
          v.removed_valid = 1'b1;
          for (int i = shadow_cur; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
        end
      end
      CMD_TO_START: shadow_cur = 0;
      CMD_TO_END:   shadow_cur = shadow_len;
      CMD_PREV:     if (shadow_cur > 0) shadow_cur--;
      CMD_NEXT:     if (shadow_cur < shadow_len) shadow_cur++;
      default: begin
        shadow_len = 0;
        shadow_cur = 0;
      end
    endcase
    if (shadow_cur < shadow_len) begin
      v.current_value = shadow_cells[shadow_cur];
      v.current_valid = 1'b1;
    end
    v.length_now   = shadow_len[LEN_W-1:0];
    v.position_now = shadow_cur[LEN_W-1:0];
    return v;
  endfunction

  // Mode 0 mostly grows the list, mode 1 mostly drains it, anything else is a free mix.
  function automatic logic [CMD_W-1:0] draw_cmd(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      if (r < 40) return CMD_INSERT;
      if (r < 70) return CMD_APPEND;
      if (r < 80) return CMD_PREV;
      if (r < 90) return CMD_NEXT;
      if (r < 95) return CMD_TO_START;
      return CMD_REMOVE;
    end else if (mode == 1) begin
      if (r < 50) return CMD_REMOVE;
      if (r < 65) return CMD_PREV;
      if (r < 80) return CMD_NEXT;
      if (r < 88) return CMD_TO_START;
      if (r < 94) return CMD_TO_END;
      if (r < 97) return CMD_INSERT;
      return CMD_CLEAR;
    end
    if (r < 3) return CMD_CLEAR;
    return CMD_W'($urandom_range(0, 6));
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_elem();
    case ($urandom_range(0, 7))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return $urandom_range(0, 1) ? 32'sd0 : NOTHING_REMOVED;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
    list_cmd_t c;
    c.cmd = cmd;
    c.val = val;
    cmd_q.push_back(c);
  endtask

  // Driver: takes items from cmd_q, predicts each one as it is accepted.
  list_cmd_t   tx_item;
  int unsigned tx_wait = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        view_q.push_back(list_apply(command, element_in));
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // Hold the stalled item unchanged.
      end else if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait--;
      end else if (cmd_q.size() > 0) begin
        tx_item = cmd_q.pop_front();
        command    <= tx_item.cmd;
        element_in <= tx_item.val;
        in_valid   <= 1'b1;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest predicted view.
  list_view_t  rx_got;
  list_view_t  rx_want;
  int unsigned rx_wait = 0;
  bit          rx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rx_got = {removed_value, removed_valid, current_value, current_valid,
                  length_now, position_now, rejected};
        if (view_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("ERROR: result with nothing expected: %p", rx_got);
        end else begin
          rx_want = view_q.pop_front();
          n_checked++;
          if (rx_want.removed_valid) n_removed++;
          if (rx_want.rejected) n_rejected++;
          if (rx_got !== rx_want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("ERROR: result %0d mismatch", n_checked);
              $display("  expected %p", rx_want);
              $display("  actual   %p", rx_got);
            end
          end
        end
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int mode;
    int burst;

    // Empty list corner cases.
    queue_cmd(CMD_CLEAR, ELEM_MAX);
    queue_cmd(CMD_REMOVE, '0);
    queue_cmd(CMD_PREV, '0);
    queue_cmd(CMD_NEXT, '0);
    queue_cmd(CMD_TO_END, '0);
    queue_cmd(CMD_INSERT, ELEM_MIN);
    queue_cmd(CMD_INSERT, ELEM_MAX);
    queue_cmd(CMD_APPEND, '0);
    queue_cmd(CMD_APPEND, NOTHING_REMOVED);
    // Fill to capacity, then both growing commands must be refused.
    for (int i = 4; i < CAPACITY; i++) queue_cmd(CMD_APPEND, $urandom);
    queue_cmd(CMD_INSERT, 32'sh1234_5678);
    queue_cmd(CMD_APPEND, 32'sh1234_5678);
    queue_cmd(CMD_TO_START, '0);
    queue_cmd(CMD_REMOVE, '0);
    queue_cmd(CMD_NEXT, '0);
    queue_cmd(CMD_PREV, '0);
    queue_cmd(CMD_TO_END, '0);
    queue_cmd(CMD_NEXT, '0);
    queue_cmd(CMD_REMOVE, '0);
    queue_cmd(CMD_CLEAR, '0);

    mode = 0;
    burst = 0;
    for (int i = 0; i < 450; i++) begin
      if (burst == 0) begin
        mode = (mode == 0) ? $urandom_range(1, 2) : $urandom_range(0, 2);
        burst = $urandom_range(20, 40);
      end
      burst--;
      queue_cmd(draw_cmd(mode), draw_elem());
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() > 0 || in_valid) @(posedge clk);
    while (view_q.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (view_q.size() > 0) begin
      n_err += view_q.size();
      $display("ERROR: %0d results never arrived", view_q.size());
    end
    $display("Summary: %0d commands sent, %0d results checked, %0d mismatches.",
             n_sent, n_checked, n_err);
    $display("Summary: %0d elements removed, %0d inserts or appends refused on a full list.",
             n_removed, n_rejected);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: the run did not complete.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cls_pkg.sv
hw/rtl/cls_ram.sv
hw/rtl/cls_datapath.sv
hw/rtl/cls_controller.sv
hw/rtl/cursor_list_store.sv
tb/tb_cursor_list_store.sv
